@@ hdl/cicd_pkg.sv @@
// Shared types and constants for the 2D cloud-in-cell charge and current deposition block.
// Depends on nothing; every module of the block imports it.
package cicd_pkg;

    localparam int GRID_X_MAX = 64;
    localparam int GRID_Y_MAX = 64;
    localparam int ACC_W      = 48;
    localparam int CELL_W     = 6;
    localparam int ADDR_W     = 2 * CELL_W;
    localparam int MEM_DEPTH  = GRID_X_MAX * GRID_Y_MAX;
    localparam int MEM_W      = 3 * ACC_W;
    localparam int Q_DEPTH    = 2;

    localparam logic [1:0] OP_DEPOSIT    = 2'd0;
    localparam logic [1:0] OP_READ_CLEAR = 2'd2;

    localparam logic [1:0] ST_DEPOSIT = 2'd0;
    localparam logic [1:0] ST_SKIP    = 2'd1;
    localparam logic [1:0] ST_READ    = 2'd2;

    localparam logic [2:0] CFG_ORIGIN_X  = 3'd0;
    localparam logic [2:0] CFG_ORIGIN_Y  = 3'd1;
    localparam logic [2:0] CFG_INV_X     = 3'd2;
    localparam logic [2:0] CFG_INV_Y     = 3'd3;
    localparam logic [2:0] CFG_INV_AREA  = 3'd4;
    localparam logic [2:0] CFG_CELLS_X   = 3'd5;
    localparam logic [2:0] CFG_CELLS_Y   = 3'd6;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic [31:0]        inv_x;
        logic [31:0]        inv_y;
        logic [31:0]        inv_area;
        logic [6:0]         cells_x;
        logic [6:0]         cells_y;
    } t_cfg;

    typedef struct packed {
        logic [1:0]         op;
        logic               outside;
        logic [CELL_W-1:0]  i0;
        logic [CELL_W-1:0]  j0;
        logic signed [17:0] fx;
        logic signed [17:0] fy;
        logic signed [31:0] q;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic [CELL_W-1:0]  cell_x;
        logic [CELL_W-1:0]  cell_y;
    } t_job;

    typedef struct packed {
        logic [1:0]              status;
        logic signed [ACC_W-1:0] rho;
        logic signed [ACC_W-1:0] jx;
        logic signed [ACC_W-1:0] jy;
        logic                    saturated;
    } t_result;

    typedef enum logic [2:0] {
        F_IDLE, F_DIFF, F_MUL, F_CLASS, F_PUSH
    } t_fstate;

    typedef enum logic [3:0] {
        B_CLEAR, B_IDLE, B_READ_ISSUE, B_READ_TAKE, B_MUL_LO, B_MUL_HI,
        B_MUL_SUM, B_MUL_SAT, B_RMW, B_RESULT
    } t_bstate;

endpackage

@@ hdl/cicd_front.sv @@
// Front end: accepts input beats, maps particle positions to base cells and fractions.
// Depends on cicd_pkg; feeds classified jobs into cicd_queue.
module cicd_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  cicd_pkg::t_cfg           i_cfg,
    input  logic                     i_hold,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [1:0]               i_operation,
    input  logic signed [31:0]       i_pos_x,
    input  logic signed [31:0]       i_pos_y,
    input  logic signed [31:0]       i_vel_x,
    input  logic signed [31:0]       i_vel_y,
    input  logic signed [31:0]       i_charge,
    input  logic [5:0]               i_cell_x,
    input  logic [5:0]               i_cell_y,
    output logic                     o_push,
    output cicd_pkg::t_job           o_job,
    input  logic                     i_full
);
    import cicd_pkg::*;

    typedef struct packed {
        logic               outside;
        logic [CELL_W-1:0]  b;
        logic signed [17:0] frac;
    } t_axis;

    function automatic logic [6:0] eff_cells(input logic [6:0] n, input logic [6:0] nmax);
        logic [6:0] r;
        if (n < 7'd2) begin
            r = 7'd2;
        end else if (n > nmax) begin
            r = nmax;
        end else begin
            r = n;
        end
        return r;
    endfunction

    function automatic t_axis axis(input logic neg, input logic [47:0] t, input logic [6:0] n);
        t_axis             a;
        logic [23:0]       s;
        logic signed [7:0] bfl;
        logic [7:0]        nm2;
        logic [23:0]       f;
        s   = {1'b0, t[22:0]} - 24'd32768;
        bfl = $signed(s[23:16]);
        nm2 = {1'b0, n} - 8'd2;
        if (bfl < 0) begin
            a.b = '0;
        end else if (bfl > $signed(nm2)) begin
            a.b = nm2[CELL_W-1:0];
        end else begin
            a.b = bfl[CELL_W-1:0];
        end
        f         = s - {2'b0, a.b, 16'b0};
        a.frac    = $signed(f[17:0]);
        a.outside = neg || (t > {25'b0, n, 16'b0});
        return a;
    endfunction

    t_fstate            r_state, n_state;
    logic [1:0]         r_op;
    logic signed [31:0] r_pos_x, r_pos_y, r_vx, r_vy, r_q;
    logic [5:0]         r_cx, r_cy;
    logic signed [32:0] r_dx, r_dy;
    logic [47:0]        r_tx, r_ty;
    logic               r_negx, r_negy;
    t_job               r_job;
    logic [63:0]        w_px, w_py;
    t_axis              w_ax, w_ay;

    assign w_px = r_dx[31:0] * i_cfg.inv_x;
    assign w_py = r_dy[31:0] * i_cfg.inv_y;
    assign w_ax = axis(r_negx, r_tx, eff_cells(i_cfg.cells_x, 7'(GRID_X_MAX)));
    assign w_ay = axis(r_negy, r_ty, eff_cells(i_cfg.cells_y, 7'(GRID_Y_MAX)));

    assign o_ready = (r_state == F_IDLE) && !i_hold;
    assign o_job   = r_job;

    always_comb begin
        n_state = r_state;
        o_push  = 1'b0;
        unique case (r_state)
            F_IDLE: begin
                if (i_valid && o_ready) begin
                    n_state = F_DIFF;
                end
            end
            F_DIFF:  n_state = F_MUL;
            F_MUL:   n_state = F_CLASS;
            F_CLASS: n_state = F_PUSH;
            F_PUSH: begin
                if (!i_full) begin
                    o_push  = 1'b1;
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == F_IDLE && i_valid && o_ready) begin
            r_op    <= i_operation;
            r_pos_x <= i_pos_x;
            r_pos_y <= i_pos_y;
            r_vx    <= i_vel_x;
            r_vy    <= i_vel_y;
            r_q     <= i_charge;
            r_cx    <= i_cell_x;
            r_cy    <= i_cell_y;
        end
        if (r_state == F_DIFF) begin
            r_dx <= 33'(r_pos_x) - 33'(i_cfg.origin_x);
            r_dy <= 33'(r_pos_y) - 33'(i_cfg.origin_y);
        end
        if (r_state == F_MUL) begin
            r_negx <= r_dx[32];
            r_negy <= r_dy[32];
            r_tx   <= w_px[63:16];
            r_ty   <= w_py[63:16];
        end
        if (r_state == F_CLASS) begin
            r_job.op      <= r_op;
            r_job.outside <= w_ax.outside || w_ay.outside;
            r_job.i0      <= w_ax.b;
            r_job.j0      <= w_ay.b;
            r_job.fx      <= w_ax.frac;
            r_job.fy      <= w_ay.frac;
            r_job.q       <= r_q;
            r_job.vx      <= r_vx;
            r_job.vy      <= r_vy;
            r_job.cell_x  <= r_cx;
            r_job.cell_y  <= r_cy;
        end
    end

endmodule

@@ hdl/cicd_queue.sv @@
// Two-entry job queue between the front end and the deposition engine.
// Depends on cicd_pkg for the job type.
module cicd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  cicd_pkg::t_job i_data,
    output logic           o_full,
    input  logic           i_pop,
    output cicd_pkg::t_job o_data,
    output logic           o_empty
);
    import cicd_pkg::*;

    localparam int PW = $clog2(Q_DEPTH);

    t_job               r_mem [Q_DEPTH];
    logic [PW-1:0]      r_wp, r_rp;
    logic [PW:0]        r_cnt;

    assign o_full  = (r_cnt == (PW+1)'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (PW+1)'(i_push) - (PW+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

@@ hdl/cicd_back.sv @@
// Deposition engine: shared multiplier sequencer, grid store with read-modify-write,
// reads and clears, and the result register. Depends on cicd_pkg.
module cicd_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [31:0]       i_area,
    input  cicd_pkg::t_job    i_job,
    input  logic              i_empty,
    output logic              o_pop,
    output logic              o_clearing,
    output logic              o_valid,
    input  logic              i_ready,
    output cicd_pkg::t_result o_res
);
    import cicd_pkg::*;

    t_bstate                 r_state, n_state;
    t_job                    r_job;
    logic [ADDR_W-1:0]       r_clr;
    logic signed [ACC_W-1:0] r_base0, r_base1, r_base2, r_w;
    logic signed [ACC_W-1:0] r_c0, r_c1, r_c2;
    logic [2:0]              r_uop;
    logic                    r_base_ph;
    logic [1:0]              r_corner, r_lane;
    logic signed [65:0]      r_prod;
    logic signed [81:0]      r_acc;
    logic                    r_sat;
    logic [MEM_W-1:0]        r_mem [MEM_DEPTH];
    logic [MEM_W-1:0]        r_rdata;
    t_result                 r_res, r_out;
    logic                    r_out_valid;

    logic signed [ACC_W-1:0] w_a;
    logic signed [32:0]      w_b, w_ma, w_mb;
    logic signed [65:0]      w_mp;
    logic signed [65:0]      w_v;
    logic                    w_in_range;
    logic signed [ACC_W-1:0] w_satres;
    logic signed [17:0]      w_wx, w_wy;
    logic [ADDR_W-1:0]       w_corner_addr;
    logic                    w_we, w_re;
    logic [ADDR_W-1:0]       w_waddr, w_raddr;
    logic [MEM_W-1:0]        w_wdata;
    logic signed [48:0]      w_s0, w_s1, w_s2;
    logic                    w_o0, w_o1, w_o2;
    logic signed [ACC_W-1:0] w_n0, w_n1, w_n2;
    logic                    w_load_out;

    assign o_clearing = (r_state == B_CLEAR);
    assign o_valid    = r_out_valid;
    assign o_res      = r_out;

    assign w_wx = r_corner[0] ? r_job.fx : 18'sd65536 - r_job.fx;
    assign w_wy = r_corner[1] ? r_job.fy : 18'sd65536 - r_job.fy;
    assign w_corner_addr = {r_job.j0 + {5'b0, r_corner[1]}, r_job.i0 + {5'b0, r_corner[0]}};

    always_comb begin
        w_a = 48'(r_job.q);
        w_b = $signed({1'b0, i_area});
        if (r_base_ph) begin
            unique case (r_uop)
                3'd1:    w_b = 33'(r_job.vx);
                3'd2:    w_a = r_base1;
                3'd3:    w_b = 33'(r_job.vy);
                3'd4:    w_a = r_base2;
                default: w_a = 48'(r_job.q);
            endcase
        end else begin
            w_b = r_w[32:0];
            unique case (r_lane)
                2'd0: begin
                    w_a = 48'(w_wx);
                    w_b = 33'(w_wy);
                end
                2'd1:    w_a = r_base0;
                2'd2:    w_a = r_base1;
                default: w_a = r_base2;
            endcase
        end
    end

    assign w_ma = (r_state == B_MUL_HI) ? 33'($signed(w_a[47:24])) : $signed({9'b0, w_a[23:0]});
    assign w_mb = w_b;
    assign w_mp = w_ma * w_mb;

    assign w_v        = r_acc[81:16];
    assign w_in_range = (&w_v[65:47]) || !(|w_v[65:47]);
    assign w_satres   = w_in_range ? w_v[47:0] : (w_v[65] ? ACC_MIN : ACC_MAX);

    assign w_s0 = 49'($signed(r_rdata[143:96])) + 49'(r_c0);
    assign w_s1 = 49'($signed(r_rdata[95:48])) + 49'(r_c1);
    assign w_s2 = 49'($signed(r_rdata[47:0])) + 49'(r_c2);
    assign w_o0 = w_s0[48] ^ w_s0[47];
    assign w_o1 = w_s1[48] ^ w_s1[47];
    assign w_o2 = w_s2[48] ^ w_s2[47];
    assign w_n0 = w_o0 ? (w_s0[48] ? ACC_MIN : ACC_MAX) : w_s0[47:0];
    assign w_n1 = w_o1 ? (w_s1[48] ? ACC_MIN : ACC_MAX) : w_s1[47:0];
    assign w_n2 = w_o2 ? (w_s2[48] ? ACC_MIN : ACC_MAX) : w_s2[47:0];

    assign w_load_out = (r_state == B_RESULT) && (!r_out_valid || i_ready);

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        w_we    = 1'b0;
        w_re    = 1'b0;
        w_waddr = w_corner_addr;
        w_raddr = w_corner_addr;
        w_wdata = {w_n0, w_n1, w_n2};
        unique case (r_state)
            B_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                w_wdata = '0;
                if (r_clr == '1) begin
                    n_state = B_IDLE;
                end
            end
            B_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    if (i_job.op != OP_DEPOSIT) begin
                        n_state = B_READ_ISSUE;
                    end else if (i_job.outside) begin
                        n_state = B_RESULT;
                    end else begin
                        n_state = B_MUL_LO;
                    end
                end
            end
            B_READ_ISSUE: begin
                w_re    = 1'b1;
                w_raddr = {r_job.cell_y, r_job.cell_x};
                n_state = B_READ_TAKE;
            end
            B_READ_TAKE: begin
                w_we    = (r_job.op == OP_READ_CLEAR);
                w_waddr = {r_job.cell_y, r_job.cell_x};
                w_wdata = '0;
                n_state = B_RESULT;
            end
            B_MUL_LO: begin
                w_re    = !r_base_ph && (r_lane == 2'd0);
                n_state = B_MUL_HI;
            end
            B_MUL_HI:  n_state = B_MUL_SUM;
            B_MUL_SUM: n_state = B_MUL_SAT;
            B_MUL_SAT: begin
                if (!r_base_ph && r_lane == 2'd3) begin
                    n_state = B_RMW;
                end else begin
                    n_state = B_MUL_LO;
                end
            end
            B_RMW: begin
                w_we    = 1'b1;
                n_state = (r_corner == 2'd3) ? B_RESULT : B_MUL_LO;
            end
            B_RESULT: begin
                if (w_load_out) begin
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == B_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rdata <= r_mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out <= r_res;
        end
        unique case (r_state)
            B_IDLE: begin
                r_job     <= i_job;
                r_sat     <= 1'b0;
                r_base_ph <= 1'b1;
                r_uop     <= '0;
                r_corner  <= '0;
                r_lane    <= '0;
                r_res     <= '{status: ST_SKIP, rho: '0, jx: '0, jy: '0, saturated: 1'b0};
            end
            B_READ_TAKE: begin
                r_res <= '{status: ST_READ, rho: $signed(r_rdata[143:96]),
                           jx: $signed(r_rdata[95:48]), jy: $signed(r_rdata[47:0]),
                           saturated: 1'b0};
            end
            B_MUL_LO: r_prod <= w_mp;
            B_MUL_HI: begin
                r_acc  <= 82'(r_prod);
                r_prod <= w_mp;
            end
            B_MUL_SUM: r_acc <= r_acc + (82'(r_prod) <<< 24);
            B_MUL_SAT: begin
                r_sat <= r_sat | !w_in_range;
                if (r_base_ph) begin
                    unique case (r_uop)
                        3'd0:       r_base0 <= w_satres;
                        3'd1, 3'd2: r_base1 <= w_satres;
                        default:    r_base2 <= w_satres;
                    endcase
                    if (r_uop == 3'd4) begin
                        r_base_ph <= 1'b0;
                    end else begin
                        r_uop <= r_uop + 3'd1;
                    end
                end else begin
                    unique case (r_lane)
                        2'd0:    r_w  <= w_satres;
                        2'd1:    r_c0 <= w_satres;
                        2'd2:    r_c1 <= w_satres;
                        default: r_c2 <= w_satres;
                    endcase
                    r_lane <= r_lane + 2'd1;
                end
            end
            B_RMW: begin
                r_sat    <= r_sat | w_o0 | w_o1 | w_o2;
                r_corner <= r_corner + 2'd1;
                r_lane   <= '0;
                r_res    <= '{status: ST_DEPOSIT, rho: '0, jx: '0, jy: '0,
                              saturated: r_sat | w_o0 | w_o1 | w_o2};
            end
            default: begin
            end
        endcase
    end

endmodule

@@ hdl/cic_charge_current_deposit_2d_core.sv @@
// Top level of the 2D cloud-in-cell deposition block: configuration registers and wiring.
// Depends on cicd_pkg, cicd_front, cicd_queue and cicd_back.
// A deposit is sequenced on the single shared 33x33 multiplier, which forms 21 products
// per deposited particle; the front end can take a new beat while the engine works on an
// earlier particle, until the two-entry queue is full.
// Reset clears control state, then the grid store is zeroed, all 4096 cells, one cell
// per cycle; no input beat is taken during that pass.
module cic_charge_current_deposit_2d_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_operation,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_vel_x,
    input  logic signed [31:0] i_vel_y,
    input  logic signed [31:0] i_charge,
    input  logic [5:0]         i_cell_x,
    input  logic [5:0]         i_cell_y,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [1:0]         o_status,
    output logic signed [47:0] o_rho_value,
    output logic signed [47:0] o_jx_value,
    output logic signed [47:0] o_jy_value,
    output logic               o_saturated
);
    import cicd_pkg::*;

    t_cfg    r_cfg;
    t_job    w_fjob, w_qjob;
    logic    w_push, w_full, w_pop, w_empty, w_clearing;
    t_result w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{origin_x: '0, origin_y: '0, inv_x: 32'd65536, inv_y: 32'd65536,
                       inv_area: 32'd65536, cells_x: 7'd64, cells_y: 7'd64};
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ORIGIN_X: r_cfg.origin_x <= $signed(i_cfg_data);
                CFG_ORIGIN_Y: r_cfg.origin_y <= $signed(i_cfg_data);
                CFG_INV_X:    r_cfg.inv_x    <= i_cfg_data;
                CFG_INV_Y:    r_cfg.inv_y    <= i_cfg_data;
                CFG_INV_AREA: r_cfg.inv_area <= i_cfg_data;
                CFG_CELLS_X:  r_cfg.cells_x  <= i_cfg_data[6:0];
                CFG_CELLS_Y:  r_cfg.cells_y  <= i_cfg_data[6:0];
                default: begin
                end
            endcase
        end
    end

    cicd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_hold      (w_clearing),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_operation (i_operation),
        .i_pos_x     (i_pos_x),
        .i_pos_y     (i_pos_y),
        .i_vel_x     (i_vel_x),
        .i_vel_y     (i_vel_y),
        .i_charge    (i_charge),
        .i_cell_x    (i_cell_x),
        .i_cell_y    (i_cell_y),
        .o_push      (w_push),
        .o_job       (w_fjob),
        .i_full      (w_full)
    );

    cicd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_fjob),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_qjob),
        .o_empty (w_empty)
    );

    cicd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_area     (r_cfg.inv_area),
        .i_job      (w_qjob),
        .i_empty    (w_empty),
        .o_pop      (w_pop),
        .o_clearing (w_clearing),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_res      (w_res)
    );

    assign o_status    = w_res.status;
    assign o_rho_value = w_res.rho;
    assign o_jx_value  = w_res.jx;
    assign o_jy_value  = w_res.jy;
    assign o_saturated = w_res.saturated;

`ifndef SYNTHESIS
    a_no_beat_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clearing |-> !o_ready)
        else $error("input taken during grid clearing pass");

    a_sat_only_on_deposit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_saturated) |-> (o_status == ST_DEPOSIT))
        else $error("saturation flag on a non-deposit result");

    a_skip_has_zero_sums: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_READ) |->
        (o_rho_value == '0 && o_jx_value == '0 && o_jy_value == '0))
        else $error("nonzero sums on a deposit or skip result");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("job pushed into a full queue");
`endif

endmodule
